### design/nabm_pkg.sv
// shared types and constants for the neighborhood adjacency bitmap unit
// no dependencies; imported by every module of the unit
package nabm_pkg;

    localparam int MAX_NEIGHBORS_DEF = 64;
    localparam int ID_BITS_DEF       = 32;

    localparam int VID_W  = 32;
    localparam int ROWI_W = 6;
    localparam int ROW_W  = 64;
    localparam int POS_W  = 6;
    localparam int KCNT_W = 7;

    // request command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_PROBE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [VID_W-1:0]  vertex_id;
        logic [ROWI_W-1:0] row_index;
    } t_nabm_req;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  position;
        logic [ROW_W-1:0]  row_bits;
        logic [KCNT_W-1:0] key_count;
        logic              overflow;
    } t_nabm_rsp;

    // controller to datapath
    typedef struct packed {
        logic cap_req;
        logic do_clear;
        logic do_load;
        logic srch_init;
        logic srch_issue;
        logic srch_cmp;
        logic row_rd;
        logic finish;
    } t_nabm_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       srch_open;
        logic       key_eq;
        logic       out_free;
    } t_nabm_sts;

endpackage

### design/nabm_ctrl.sv
// sequencing state machine of the neighborhood adjacency bitmap unit
// depends on nabm_pkg; drives the datapath through t_nabm_cmd
module nabm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  nabm_pkg::t_nabm_sts i_sts,
    output nabm_pkg::t_nabm_cmd o_cmd
);
    import nabm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SRCH_RD  = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_ROW_RD   = 3'd4;
    localparam logic [2:0] S_ROW_WR   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_req = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.command)
                    CMD_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state        = S_ROW_RD;
                    end
                    CMD_LOAD: begin
                        o_cmd.do_load = 1'b1;
                        n_state       = S_ROW_RD;
                    end
                    CMD_PROBE: begin
                        o_cmd.srch_init = 1'b1;
                        n_state         = S_SRCH_RD;
                    end
                    default: begin
                        n_state = S_ROW_RD;
                    end
                endcase
            end
            S_SRCH_RD: begin
                if (i_sts.srch_open) begin
                    o_cmd.srch_issue = 1'b1;
                    n_state          = S_SRCH_CMP;
                end else begin
                    n_state = S_ROW_RD;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = i_sts.key_eq ? S_ROW_RD : S_SRCH_RD;
            end
            S_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_ROW_WR;
            end
            S_ROW_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/nabm_dp.sv
// datapath: key memory, row memory, binary search bounds, result register
// depends on nabm_pkg; steered by nabm_ctrl through t_nabm_cmd
module nabm_dp #(
    parameter int MAX_NEIGHBORS = nabm_pkg::MAX_NEIGHBORS_DEF,
    parameter int ID_BITS       = nabm_pkg::ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nabm_pkg::t_nabm_req i_in_req,
    input  nabm_pkg::t_nabm_cmd i_cmd,
    output nabm_pkg::t_nabm_sts o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output nabm_pkg::t_nabm_rsp o_out_rsp
);
    import nabm_pkg::*;

    localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_NEIGHBORS);

    t_nabm_req          r_req;
    logic [ID_BITS-1:0] r_key_mem [MAX_NEIGHBORS];
    logic [ID_BITS-1:0] r_key_q;
    logic [ROW_W-1:0]   r_row_mem [MAX_NEIGHBORS];
    logic [ROW_W-1:0]   r_row_q;
    logic [MAX_NEIGHBORS-1:0] r_row_vld;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [AW-1:0]      r_mid;
    logic [AW-1:0]      r_pos;
    logic               r_hit;
    logic               r_ovf;
    logic               r_out_valid;
    t_nabm_rsp          r_out_rsp;

    logic [ID_BITS-1:0] id_v;
    logic [AW-1:0]      row_addr;
    logic               row_ok;
    logic [CW:0]        mid_sum;
    logic [AW-1:0]      n_mid;
    logic               full;
    logic               key_lt;
    logic               key_eq;
    logic               out_free;
    logic               row_we;
    logic [ROW_W-1:0]   row_cur;
    logic [ROW_W-1:0]   row_new;
    logic [ROW_W-1:0]   res_row;

    // key width follows ID_BITS, wider ids zero extend
    assign id_v     = ID_BITS'(r_req.vertex_id);
    assign row_addr = r_req.row_index[AW-1:0];
    assign row_ok   = {1'b0, r_req.row_index} < KCNT_W'(MAX_NEIGHBORS);

    // bounds kept as [lo, hi) so mid = floor((lo + hi - 1) / 2)
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} - (CW + 1)'(1);
    assign n_mid   = AW'(mid_sum[CW:1]);

    assign full   = (r_count == COUNT_MAX);
    assign key_lt = (r_key_q < id_v);
    assign key_eq = (r_key_q == id_v);

    assign out_free = !r_out_valid || !i_out_stall;
    assign row_we   = i_cmd.finish && r_hit && row_ok;

    assign row_cur = (row_ok && r_row_vld[row_addr]) ? r_row_q : '0;
    assign row_new = row_cur | (r_hit ? (ROW_W'(1) << r_pos) : '0);
    assign res_row = row_ok ? row_new : '0;

    assign o_sts.command   = r_req.command;
    assign o_sts.srch_open = (r_lo < r_hi);
    assign o_sts.key_eq    = key_eq;
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // key memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_load && !full) begin
            r_key_mem[r_count[AW-1:0]] <= id_v;
        end
        if (i_cmd.srch_issue) begin
            r_key_q <= r_key_mem[n_mid];
        end
    end

    // row memory, read then written back on a probe hit
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_addr] <= row_new;
        end
        if (i_cmd.row_rd) begin
            r_row_q <= r_row_mem[row_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_clear) begin
                r_count   <= '0;
                r_row_vld <= '0;
            end else begin
                if (i_cmd.do_load && !full) begin
                    r_count <= r_count + CW'(1);
                end
                if (row_we) begin
                    r_row_vld[row_addr] <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_req) begin
            r_req <= i_in_req;
            r_hit <= 1'b0;
            r_pos <= '0;
            r_ovf <= 1'b0;
        end
        if (i_cmd.do_load && full) begin
            r_ovf <= 1'b1;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_cmd.srch_issue) begin
            r_mid <= n_mid;
        end
        if (i_cmd.srch_cmp) begin
            if (key_eq) begin
                r_hit <= 1'b1;
                r_pos <= r_mid;
            end else if (key_lt) begin
                r_lo <= CW'(r_mid) + CW'(1);
            end else begin
                r_hi <= CW'(r_mid);
            end
        end
        if (i_cmd.finish) begin
            r_out_rsp.hit       <= r_hit;
            r_out_rsp.position  <= POS_W'(r_pos);
            r_out_rsp.row_bits  <= res_row;
            r_out_rsp.key_count <= KCNT_W'(r_count);
            r_out_rsp.overflow  <= r_ovf;
        end
    end

endmodule

### design/neighborhood_adjacency_bitmap_unit.sv
// top level of the neighborhood adjacency bitmap unit
// depends on nabm_pkg, nabm_ctrl and nabm_dp
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_stall   i_in_req   (t_nabm_req)
//   response  out        o_out_valid / i_out_stall o_out_rsp  (t_nabm_rsp)
//
// one request at a time; clear, load and read pass through execute, row read and
// row write before the next accept, a probe also through its binary search, each
// step a read state and a compare state through the key memory's registered read port
// reset clears the key count, the response valid flag and the per-row valid bits at
// once; no memory sweep, the block takes requests as soon as reset is released
// a finished response waits in the output register while the next request is
// accepted; the controller only stalls its last step if that register is still full and stalled
module neighborhood_adjacency_bitmap_unit #(
    parameter int MAX_NEIGHBORS = nabm_pkg::MAX_NEIGHBORS_DEF,
    parameter int ID_BITS       = nabm_pkg::ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  nabm_pkg::t_nabm_req i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nabm_pkg::t_nabm_rsp o_out_rsp
);
    import nabm_pkg::*;

    // command and status between sequencer and datapath
    t_nabm_cmd ctl_cmd;
    t_nabm_sts dp_sts;

    // sequencer: accept, execute, search steps, row read-modify-write
    nabm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (ctl_cmd)
    );

    // datapath: key table, adjacency rows, search bounds, response register
    nabm_dp #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .ID_BITS       (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (ctl_cmd),
        .o_sts       (dp_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

    // a response is only written when the output register can take it
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.finish |-> dp_sts.out_free)
        else $error("response written over a held response");

    // an accepted request keeps the input stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one in flight");

    // key count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.key_count <= KCNT_W'(MAX_NEIGHBORS)))
        else $error("key count beyond table depth");

    // a hit names a loaded key and never comes with overflow
    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.hit) |->
            ((KCNT_W'(o_out_rsp.position) < o_out_rsp.key_count) && !o_out_rsp.overflow))
        else $error("hit position outside loaded keys");

endmodule
